[src/use_hint_highbits_pack_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef USE_HINT_HIGHBITS_PACK_ASSERT_SVH
`define USE_HINT_HIGHBITS_PACK_ASSERT_SVH

// Same-cycle implication: when cond holds, expr must hold.
`define UHP_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication: when cond holds, expr must hold in the next cycle.
`define UHP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[src/uhp_pkg.sv]
package uhp_pkg;

	localparam int COEFFS_PER_ROW = 256;
	localparam int IDX_W = $clog2(COEFFS_PER_ROW);

	localparam int COEF_W = 24;
	localparam int A_W = COEF_W + 1;
	localparam int T_W = A_W - 7;
	localparam int PROD_W = 33;
	localparam int A0_W = 27;
	localparam int A1_W = 6;
	localparam int BYTE_W = 8;

	localparam logic signed [A_W-1:0] Q_MOD = A_W'(8380417);
	localparam logic signed [A_W-1:0] RND_ADD = A_W'(127);
	localparam int RND_SHIFT = 7;
	localparam logic signed [PROD_W-1:0] MUL_C = PROD_W'(11275);
	localparam logic signed [PROD_W-1:0] MUL_RND = PROD_W'(1 << 23);
	localparam int MUL_SHIFT = 24;
	localparam logic [A1_W-1:0] A1_MAX = A1_W'(43);
	localparam logic [A0_W-1:0] ALPHA = A0_W'(190464);
	localparam logic signed [A0_W-1:0] HALF_Q = A0_W'(4190208);
	localparam logic signed [A0_W-1:0] Q_MOD_W = A0_W'(8380417);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int ROW_REM = COEFFS_PER_ROW % 4;
	localparam int BYTES_PER_ROW = 3 * (COEFFS_PER_ROW / 4)
		+ ((ROW_REM == 0) ? 0 : ((ROW_REM == 3) ? 2 : 1));
	localparam int BYTE_CNT_W = $clog2(BYTES_PER_ROW);

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2,
		POS_FOURTH = 2'd3
	} pos_t;

	typedef struct packed {
		pos_t pos;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [A1_W-1:0] a1;
		tag_t tag;
	} entry_t;

endpackage

[src/uhp_if.sv]
interface uhp_coef_if;
	logic valid;
	logic ready;
	logic signed [uhp_pkg::COEF_W-1:0] coefficient;
	logic hint;

	modport source(output valid, coefficient, hint, input ready);
	modport sink(input valid, coefficient, hint, output ready);
endinterface

interface uhp_byte_if;
	logic valid;
	logic ready;
	logic [uhp_pkg::BYTE_W-1:0] packed_byte;
	logic row_done;

	modport source(output valid, packed_byte, row_done, input ready);
	modport sink(input valid, packed_byte, row_done, output ready);
endinterface

[src/uhp_front.sv]
module uhp_front (
	input  logic clk,
	input  logic arst_n,
	uhp_coef_if.sink coef,
	output logic push_valid,
	output uhp_pkg::entry_t push_entry,
	input  logic push_ready
);

	logic en;
	logic accept;
	logic [uhp_pkg::IDX_W-1:0] idx_q;
	uhp_pkg::tag_t tag_in;

	logic valid_s1;
	logic signed [uhp_pkg::A_W-1:0] a_s1;
	logic hint_s1;
	uhp_pkg::tag_t tag_s1;

	logic valid_s2;
	logic signed [uhp_pkg::A_W-1:0] a_s2;
	logic signed [uhp_pkg::PROD_W-1:0] prod_s2;
	logic hint_s2;
	uhp_pkg::tag_t tag_s2;

	logic signed [uhp_pkg::A_W-1:0] a_in;
	logic signed [uhp_pkg::A_W-1:0] a_rnd;
	logic signed [uhp_pkg::T_W-1:0] t_s1;
	logic signed [uhp_pkg::PROD_W-1:0] prod_in;

	logic signed [uhp_pkg::PROD_W-1:0] sum;
	logic signed [uhp_pkg::PROD_W-uhp_pkg::MUL_SHIFT-1:0] a1_raw;
	logic [uhp_pkg::A1_W-1:0] a1_c;
	logic [uhp_pkg::A0_W-1:0] a1_mul;
	logic signed [uhp_pkg::A0_W-1:0] a_ext;
	logic signed [uhp_pkg::A0_W-1:0] a0_raw;
	logic signed [uhp_pkg::A0_W-1:0] a0_adj;
	logic up;
	logic [uhp_pkg::A1_W-1:0] a1_fin;

	assign en = !valid_s2 || push_ready;
	assign coef.ready = en;
	assign accept = coef.valid && en;

	assign tag_in.pos = uhp_pkg::pos_t'(idx_q[1:0]);
	assign tag_in.last = (idx_q == uhp_pkg::IDX_W'(uhp_pkg::COEFFS_PER_ROW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= tag_in.last ? '0 : idx_q + 1'b1;
		end
	end

	// Negative coefficients are lifted by Q before the high-bits split.
	assign a_in = {coef.coefficient[uhp_pkg::COEF_W-1], coef.coefficient}
		+ (coef.coefficient[uhp_pkg::COEF_W-1] ? uhp_pkg::Q_MOD : '0);

	assign a_rnd = a_s1 + uhp_pkg::RND_ADD;
	assign t_s1 = uhp_pkg::T_W'(a_rnd >>> uhp_pkg::RND_SHIFT);
	assign prod_in = uhp_pkg::PROD_W'(t_s1) * uhp_pkg::MUL_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			hint_s1 <= coef.hint;
			tag_s1 <= tag_in;
			a_s2 <= a_s1;
			prod_s2 <= prod_in;
			hint_s2 <= hint_s1;
			tag_s2 <= tag_s1;
		end
	end

	assign sum = prod_s2 + uhp_pkg::MUL_RND;
	assign a1_raw = sum[uhp_pkg::PROD_W-1:uhp_pkg::MUL_SHIFT];

	always_comb begin
		if (a1_raw < 0 || a1_raw > $signed({1'b0, uhp_pkg::A1_MAX})) begin
			a1_c = '0;
		end else begin
			a1_c = a1_raw[uhp_pkg::A1_W-1:0];
		end
	end

	assign a1_mul = uhp_pkg::A0_W'(a1_c) * uhp_pkg::ALPHA;
	assign a_ext = uhp_pkg::A0_W'(a_s2);
	assign a0_raw = a_ext - $signed(a1_mul);
	assign a0_adj = (a0_raw > uhp_pkg::HALF_Q) ? a0_raw - uhp_pkg::Q_MOD_W : a0_raw;
	assign up = (a0_adj > 0);

	always_comb begin
		if (!hint_s2) begin
			a1_fin = a1_c;
		end else if (up) begin
			a1_fin = (a1_c == uhp_pkg::A1_MAX) ? '0 : a1_c + 1'b1;
		end else begin
			a1_fin = (a1_c == '0) ? uhp_pkg::A1_MAX : a1_c - 1'b1;
		end
	end

	assign push_valid = valid_s2;
	assign push_entry.a1 = a1_fin;
	assign push_entry.tag = tag_s2;

endmodule

[src/uhp_queue.sv]
module uhp_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  uhp_pkg::entry_t push_entry,
	output logic push_ready,
	output logic pop_valid,
	output uhp_pkg::entry_t pop_entry,
	input  logic pop_ready
);

	uhp_pkg::entry_t slots_q [uhp_pkg::QDEPTH];
	logic [uhp_pkg::QPTR_W-1:0] wr_q;
	logic [uhp_pkg::QPTR_W-1:0] rd_q;
	logic [uhp_pkg::QCNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (cnt_q != uhp_pkg::QCNT_W'(uhp_pkg::QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = slots_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == uhp_pkg::QPTR_W'(uhp_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == uhp_pkg::QPTR_W'(uhp_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

endmodule

[src/uhp_back.sv]
module uhp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	input  uhp_pkg::entry_t pop_entry,
	output logic pop_ready,
	uhp_byte_if.source pack
);

	logic out_valid_q;
	logic [uhp_pkg::BYTE_W-1:0] byte_q;
	logic done_q;
	logic [uhp_pkg::A1_W-1:0] pend_q;

	logic do_pop;
	logic emit;
	logic [uhp_pkg::BYTE_W-1:0] byte_nxt;
	logic [uhp_pkg::A1_W-1:0] pend_nxt;
	logic [uhp_pkg::A1_W-1:0] a1;

	assign pop_ready = !out_valid_q || pack.ready;
	assign do_pop = pop_valid && pop_ready;
	assign a1 = pop_entry.a1;

	always_comb begin
		unique case (pop_entry.tag.pos)
			uhp_pkg::POS_FIRST: begin
				byte_nxt = uhp_pkg::BYTE_W'(a1);
				pend_nxt = a1;
				emit = pop_entry.tag.last;
			end
			uhp_pkg::POS_SECOND: begin
				byte_nxt = {a1[1:0], pend_q};
				pend_nxt = {2'b00, a1[5:2]};
				emit = 1'b1;
			end
			uhp_pkg::POS_THIRD: begin
				byte_nxt = {a1[3:0], pend_q[3:0]};
				pend_nxt = {4'b0000, a1[5:4]};
				emit = 1'b1;
			end
			default: begin
				byte_nxt = {a1, pend_q[1:0]};
				pend_nxt = '0;
				emit = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q <= '0;
		end else begin
			if (do_pop) begin
				pend_q <= pop_entry.tag.last ? '0 : pend_nxt;
			end
			if (do_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (pack.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && emit) begin
			byte_q <= byte_nxt;
			done_q <= pop_entry.tag.last;
		end
	end

	assign pack.valid = out_valid_q;
	assign pack.packed_byte = byte_q;
	assign pack.row_done = done_q;

endmodule

[src/use_hint_highbits_pack.sv]
// Channel  Dir  Payload                               Accepted when
// coef     in   coefficient (s24), hint (1)           valid && ready
// pack     out  packed_byte (8), row_done (1)         valid && ready
//
// One coefficient is taken per cycle while coef ready is high; a word leaves for three of every four.
// After its last coefficient is taken, a word passes through two arithmetic
// stages, a queue slot and the output register before it is valid.
// Reset clears the row counter, the carried bits, the queue and all valid flags.
// The four-entry queue absorbs output stalls; input ready drops once it is full
// and the second arithmetic stage is held.
module use_hint_highbits_pack (
	input  logic clk,
	input  logic arst_n,
	uhp_coef_if.sink coef,
	uhp_byte_if.source pack
);

	logic push_valid;
	logic push_ready;
	uhp_pkg::entry_t push_entry;
	logic pop_valid;
	logic pop_ready;
	uhp_pkg::entry_t pop_entry;

	uhp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.push_ready(push_ready)
	);

	uhp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.push_ready(push_ready),
		.pop_valid(pop_valid),
		.pop_entry(pop_entry),
		.pop_ready(pop_ready)
	);

	uhp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_entry(pop_entry),
		.pop_ready(pop_ready),
		.pack(pack)
	);

endmodule

[src/uhp_checker.sv]
`include "use_hint_highbits_pack_assert.svh"

module uhp_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [uhp_pkg::BYTE_W-1:0] out_byte,
	input logic out_done
);

	localparam logic [uhp_pkg::BYTE_CNT_W-1:0] LAST_BYTE =
		uhp_pkg::BYTE_CNT_W'(uhp_pkg::BYTES_PER_ROW - 1);

	logic [uhp_pkg::BYTE_CNT_W-1:0] cnt_q;
	logic out_acc;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_acc) begin
			cnt_q <= out_done ? '0 : cnt_q + 1'b1;
		end
	end

	`UHP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_done), "stalled word changed")
	`UHP_ASSERT_IMPL(a_done_at_end, clk, arst_n, out_acc && out_done, cnt_q == LAST_BYTE, "row end flagged at wrong word")
	`UHP_ASSERT_IMPL(a_end_flagged, clk, arst_n, out_acc && cnt_q == LAST_BYTE, out_done, "last word of row not flagged")

endmodule

bind use_hint_highbits_pack uhp_checker u_uhp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(pack.valid),
	.out_ready(pack.ready),
	.out_byte(pack.packed_byte),
	.out_done(pack.row_done)
);

[test/tb_use_hint_highbits_pack.sv]
module tb_use_hint_highbits_pack;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MODULUS = 8380417;
	localparam longint ALPHA2 = 190464;
	localparam longint HALF_MODULUS = 4190208;
	localparam int RANDOM_PER_PHASE = 500;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [uhp_pkg::BYTE_W-1:0] packed_byte;
		logic row_done;
	} pack_word_t;

	typedef struct {
		logic signed [uhp_pkg::COEF_W-1:0] coefficient;
		logic hint;
		int a1_typed;
	} directed_row_t;

	logic clk;
	logic arst_n;

	uhp_coef_if coef_ch ();
	uhp_byte_if pack_ch ();

	use_hint_highbits_pack dut (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef_ch),
		.pack(pack_ch)
	);

	pack_word_t expected_words[$];
	logic [7:0] row_pos;
	logic [5:0] carry_bits;
	int errors;
	int src_idle;
	int snk_idle;

	// A typed a1 of -1 means the value is worked out from the coefficient.
	directed_row_t directed_rows[22] = '{
		'{0, 1'b0, 0},
		'{0, 1'b1, 43},
		'{8380416, 1'b0, 0},
		'{8380416, 1'b1, 43},
		'{-1, 1'b1, 43},
		'{8380417, 1'b0, 0},
		'{8380417, 1'b1, 43},
		'{-8380417, 1'b0, 0},
		'{-8380417, 1'b1, 43},
		'{8388607, 1'b0, -1},
		'{8388607, 1'b1, -1},
		'{-8388608, 1'b0, 0},
		'{-8388608, 1'b1, 43},
		'{190464, 1'b0, -1},
		'{190464, 1'b1, -1},
		'{95232, 1'b1, -1},
		'{95233, 1'b1, -1},
		'{8189952, 1'b1, -1},
		'{8285184, 1'b1, 0},
		'{8285185, 1'b0, 0},
		'{8285185, 1'b1, -1},
		'{-95232, 1'b0, -1}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drives one coefficient, waits for it to be taken and then adds the word
	// it completes, if any, to the list of expected words.
	task automatic drive_coefficient(input logic signed [uhp_pkg::COEF_W-1:0] value,
		input logic hint_bit, input int a1_typed);
		longint a;
		longint t;
		longint a1;
		longint a0;
		logic [5:0] hb;
		logic [7:0] out_byte;
		logic emit;
		logic last_coef;
		while ($urandom_range(0, 99) < src_idle) begin
			coef_ch.valid <= 1'b0;
			@(posedge clk);
		end
		coef_ch.valid <= 1'b1;
		coef_ch.coefficient <= value;
		coef_ch.hint <= hint_bit;
		do @(posedge clk); while (!coef_ch.ready);

		a = value;
		if (a < 0)
			a += MODULUS;
		t = (a + 127) >>> 7;
		a1 = (t * 11275 + (longint'(1) << 23)) >>> 24;
		if (a1 > 43 || a1 < 0)
			a1 = 0;
		a0 = a - a1 * ALPHA2;
		if (a0 > HALF_MODULUS)
			a0 -= MODULUS;
		if (hint_bit) begin
			if (a0 > 0)
				a1 = (a1 == 43) ? 0 : a1 + 1;
			else
				a1 = (a1 == 0) ? 43 : a1 - 1;
		end
		hb = (a1_typed >= 0) ? 6'(a1_typed) : 6'(a1);

		last_coef = (int'(row_pos) >= uhp_pkg::COEFFS_PER_ROW - 1);
		emit = 1'b1;
		case (uhp_pkg::pos_t'(row_pos[1:0]))
			uhp_pkg::POS_FIRST: begin
				carry_bits = hb;
				out_byte = 8'(hb);
				emit = last_coef;
			end
			uhp_pkg::POS_SECOND: begin
				out_byte = {hb[1:0], carry_bits};
				carry_bits = 6'(hb >> 2);
			end
			uhp_pkg::POS_THIRD: begin
				out_byte = {hb[3:0], carry_bits[3:0]};
				carry_bits = 6'(hb >> 4);
			end
			default: begin
				out_byte = {hb, carry_bits[1:0]};
				carry_bits = '0;
			end
		endcase
		if (emit)
			expected_words.push_back('{packed_byte: out_byte, row_done: last_coef});
		if (last_coef) begin
			row_pos = '0;
			carry_bits = '0;
		end else begin
			row_pos = row_pos + 8'd1;
		end
	endtask

	initial begin
		int phase;
		int sel;
		int k;
		int offs;
		int v;
		arst_n = 1'b0;
		coef_ch.valid = 1'b0;
		coef_ch.coefficient = '0;
		coef_ch.hint = 1'b0;
		row_pos = '0;
		carry_bits = '0;
		errors = 0;
		src_idle = 36;
		snk_idle = 59;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			drive_coefficient(directed_rows[i].coefficient, directed_rows[i].hint,
				directed_rows[i].a1_typed);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle = 36;
					snk_idle = 59;
				end
				1: begin
					src_idle = 59;
					snk_idle = 36;
				end
				default: begin
					src_idle = 0;
					snk_idle = 0;
				end
			endcase
			coef_ch.valid <= 1'b0;
			@(posedge clk);
			while (expected_words.size() > 0)
				@(posedge clk);
			repeat (RANDOM_PER_PHASE) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					v = int'($urandom_range(0, 2 * 8380417)) - 8380417;
				end else if (sel < 8) begin
					k = $urandom_range(0, 44);
					offs = int'($urandom_range(0, 4)) - 2 + ($urandom_range(0, 1) ? 95232 : 0);
					v = k * 190464 + offs;
					if ($urandom_range(0, 1))
						v = -v;
				end else begin
					v = $urandom;
				end
				drive_coefficient(uhp_pkg::COEF_W'(v), 1'($urandom_range(0, 1)), -1);
			end
		end

		coef_ch.valid <= 1'b0;
		while (expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		pack_word_t want;
		pack_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pack_ch.valid && pack_ch.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: word with none expected, actual packed_byte %02h row_done %b",
						$time, pack_ch.packed_byte, pack_ch.row_done);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (pack_ch.packed_byte !== want.packed_byte) begin
						$display("%0t: packed_byte expected %02h actual %02h",
							$time, want.packed_byte, pack_ch.packed_byte);
						errors++;
					end
					if (pack_ch.row_done !== want.row_done) begin
						$display("%0t: row_done expected %b actual %b",
							$time, want.row_done, pack_ch.row_done);
						errors++;
					end
				end
			end
			pack_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	initial begin
		int stall;
		stall = 0;
		wait (arst_n === 1'b1);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((coef_ch.valid && coef_ch.ready) || (pack_ch.valid && pack_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
